### design/kpsp_pkg.sv
// Shared types and constants of the keyed packet stream parser.
// Used by the front parser, the step queue and the output stage.
`timescale 1ns / 1ps

package kpsp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_VEND   = 2'd2;
    localparam logic [1:0] KIND_PEND   = 2'd3;

    // Framing constants
    localparam int unsigned HDR_BYTES = 20;
    localparam logic [7:0]  SEP_HI    = 8'hC0;
    localparam logic [7:0]  SEP_LO    = 8'h80;
    localparam logic [7:0]  PAD_BYTE  = 8'h00;

    // Latched header fields
    typedef struct packed {
        logic [31:0] version;
        logic [15:0] length;
        logic [15:0] service;
        logic [31:0] status;
        logic [31:0] session;
    } kpsp_hdr_t;

    // All results caused by one input word (one or two)
    typedef struct packed {
        logic       two;
        logic [1:0] kind0;
        logic [7:0] data0;
        logic [1:0] kind1;
        logic [7:0] data1;
        logic [15:0] key;
        kpsp_hdr_t  hdr;
    } kpsp_step_t;

endpackage

### design/kpsp_front.sv
// Front parser: accepts stream words, tracks header/key/value framing and
// turns each word into zero, one or two results. Depends on kpsp_pkg.
`timescale 1ns / 1ps

module kpsp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stream_valid,
    output logic                 stream_ready,
    input  logic [7:0]           stream_byte,
    input  logic                 q_full,
    output logic                 push,
    output kpsp_pkg::kpsp_step_t push_data
);
    import kpsp_pkg::*;

    localparam logic [2:0] PH_PAD  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_KEY  = 3'd2;
    localparam logic [2:0] PH_VAL  = 3'd3;
    localparam logic [2:0] PH_DROP = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_LATE = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [16:0] count_reg, count_next;
    kpsp_hdr_t   hdr_reg, hdr_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  flags_reg, flags_next;
    logic        held_reg, held_next;

    logic        accept;
    logic [1:0]  nres;
    logic [1:0]  kind0, kind1;
    logic [7:0]  data0, data1;
    logic [15:0] keyv;

    assign stream_ready = !q_full;
    assign accept       = stream_valid && stream_ready;

    // Work out the effect of one word on the parser state
    always_comb
    begin
        logic [7:0]  b;
        logic        do_hdr;
        logic        last;
        logic [19:0] prod;
        logic [3:0]  digit;

        b          = stream_byte;
        do_hdr     = 1'b0;
        phase_next = phase_reg;
        count_next = count_reg;
        hdr_next   = hdr_reg;
        acc_next   = acc_reg;
        flags_next = flags_reg;
        held_next  = held_reg;
        nres       = 2'd0;
        kind0      = KIND_HEADER;
        kind1      = KIND_HEADER;
        data0      = 8'd0;
        data1      = 8'd0;
        keyv       = 16'd0;
        last       = ({1'b0, count_reg} + 18'd1) >= {2'd0, hdr_reg.length};
        digit      = 4'(b - 8'h30);
        prod       = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {16'd0, digit};

        case (phase_reg)
            PH_HDR:
            begin
                do_hdr = 1'b1;
            end
            PH_KEY, PH_VAL, PH_DROP, PH_SKIP:
            begin
                count_next = count_reg + 17'd1;
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (b == SEP_LO)
                    begin
                        // complete a separator
                        if (phase_next == PH_KEY)
                        begin
                            phase_next = flags_next[0] ? PH_VAL : PH_DROP;
                        end
                        else if (phase_next == PH_VAL)
                        begin
                            keyv = flags_next[1] ? 16'd0 : acc_next;
                            kind0 = KIND_VEND;
                            nres = 2'd1;
                            acc_next = 16'd0;
                            flags_next = 2'b00;
                            phase_next = PH_KEY;
                        end
                        else if (phase_next == PH_DROP)
                        begin
                            acc_next = 16'd0;
                            flags_next = 2'b00;
                            phase_next = PH_KEY;
                        end
                    end
                    else
                    begin
                        // held C0 was plain data
                        if (phase_next == PH_KEY)
                        begin
                            flags_next = 2'b11;
                        end
                        else if (phase_next == PH_VAL)
                        begin
                            keyv = flags_next[1] ? 16'd0 : acc_next;
                            kind0 = KIND_BYTE;
                            data0 = SEP_HI;
                            nres = 2'd1;
                        end
                    end
                end
                // candidate byte before the final one
                if (!last && !(held_reg && b == SEP_LO) && phase_next != PH_SKIP)
                begin
                    if (phase_next == PH_KEY && !flags_next[0] && b == PAD_BYTE)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (b == SEP_HI)
                    begin
                        held_next = 1'b1;
                    end
                    else if (phase_next == PH_KEY)
                    begin
                        flags_next[0] = 1'b1;
                        if (b >= 8'h30 && b <= 8'h39)
                        begin
                            if (!flags_next[1])
                            begin
                                if (prod > 20'hFFFF)
                                begin
                                    flags_next[1] = 1'b1;
                                end
                                else
                                begin
                                    acc_next = prod[15:0];
                                end
                            end
                        end
                        else
                        begin
                            flags_next[1] = 1'b1;
                        end
                    end
                    else if (phase_next == PH_VAL)
                    begin
                        keyv = flags_next[1] ? 16'd0 : acc_next;
                        if (nres == 2'd0)
                        begin
                            kind0 = KIND_BYTE;
                            data0 = b;
                        end
                        else
                        begin
                            kind1 = KIND_BYTE;
                            data1 = b;
                        end
                        nres = nres + 2'd1;
                    end
                end
                // close the body on its final byte
                if (last)
                begin
                    if (phase_next == PH_VAL || (phase_next == PH_KEY && flags_next[0]))
                    begin
                        keyv = flags_next[1] ? 16'd0 : acc_next;
                        if (nres == 2'd0)
                        begin
                            kind0 = KIND_VEND;
                        end
                        else
                        begin
                            kind1 = KIND_VEND;
                        end
                        nres = nres + 2'd1;
                    end
                    acc_next   = 16'd0;
                    flags_next = 2'b00;
                    held_next  = 1'b0;
                    count_next = 17'd0;
                    if (nres == 2'd2)
                    begin
                        phase_next = PH_LATE;
                    end
                    else
                    begin
                        if (nres == 2'd0)
                        begin
                            kind0 = KIND_PEND;
                        end
                        else
                        begin
                            kind1 = KIND_PEND;
                        end
                        nres = nres + 2'd1;
                        phase_next = PH_PAD;
                    end
                end
            end
            PH_LATE:
            begin
                // deliver the held-over packet end, then treat the word as in the idle phase
                kind0 = KIND_PEND;
                nres = 2'd1;
                phase_next = PH_PAD;
                if (b != PAD_BYTE)
                begin
                    phase_next = PH_HDR;
                    count_next = 17'd0;
                    do_hdr = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_PAD;
                if (b != PAD_BYTE)
                begin
                    phase_next = PH_HDR;
                    count_next = 17'd0;
                    do_hdr = 1'b1;
                end
            end
        endcase

        // shift a header word into its field; words 0 to 3 are not kept
        if (do_hdr)
        begin
            if (count_next inside {[17'd4:17'd7]})
            begin
                hdr_next.version = {hdr_next.version[23:0], b};
            end
            else if (count_next inside {[17'd8:17'd9]})
            begin
                hdr_next.length = {hdr_next.length[7:0], b};
            end
            else if (count_next inside {[17'd10:17'd11]})
            begin
                hdr_next.service = {hdr_next.service[7:0], b};
            end
            else if (count_next inside {[17'd12:17'd15]})
            begin
                hdr_next.status = {hdr_next.status[23:0], b};
            end
            else if (count_next inside {[17'd16:17'd19]})
            begin
                hdr_next.session = {hdr_next.session[23:0], b};
            end
            count_next = count_next + 17'd1;
            if (count_next >= 17'(HDR_BYTES))
            begin
                if (nres == 2'd0)
                begin
                    kind0 = KIND_HEADER;
                end
                else
                begin
                    kind1 = KIND_HEADER;
                end
                nres       = nres + 2'd1;
                count_next = 17'd0;
                acc_next   = 16'd0;
                flags_next = 2'b00;
                held_next  = 1'b0;
                if (hdr_next.length == 16'd0)
                begin
                    kind1      = KIND_PEND;
                    nres       = 2'd2;
                    phase_next = PH_PAD;
                end
                else
                begin
                    phase_next = PH_KEY;
                end
            end
        end
    end

    // Hand the word's results to the queue
    assign push            = accept && (nres != 2'd0);
    assign push_data.two   = (nres == 2'd2);
    assign push_data.kind0 = kind0;
    assign push_data.data0 = data0;
    assign push_data.kind1 = kind1;
    assign push_data.data1 = data1;
    assign push_data.key   = keyv;
    assign push_data.hdr   = hdr_next;

    // Advance parser state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PAD;
            count_reg <= 17'd0;
            hdr_reg   <= '0;
            acc_reg   <= 16'd0;
            flags_reg <= 2'b00;
            held_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
            held_reg  <= held_next;
        end
    end

endmodule

### design/kpsp_queue.sv
// Two-entry queue of per-word result groups between front parser and
// output stage. Depends on kpsp_pkg.
`timescale 1ns / 1ps

module kpsp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kpsp_pkg::kpsp_step_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output kpsp_pkg::kpsp_step_t head
);
    import kpsp_pkg::*;

    kpsp_step_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill level out of range");

endmodule

### design/kpsp_back.sv
// Output stage: unpacks one or two results per queue entry into a
// registered result channel. Depends on kpsp_pkg.
`timescale 1ns / 1ps

module kpsp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  kpsp_pkg::kpsp_step_t q_head,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           kind,
    output logic [31:0]          version_word,
    output logic [15:0]          body_length,
    output logic [15:0]          service_code,
    output logic [31:0]          status_code,
    output logic [31:0]          session_word,
    output logic [15:0]          key_number,
    output logic [7:0]           data_byte
);
    import kpsp_pkg::*;

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [1:0] pkind_reg, pkind_next;
    logic [7:0] pdata_reg, pdata_next;
    logic [15:0] key_reg, key_next;
    kpsp_hdr_t  hdr_reg, hdr_next;
    logic       load;

    assign load = !valid_reg || result_ready;

    // Load the pending second result, else pop the next entry
    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        pkind_next = pkind_reg;
        pdata_next = pdata_reg;
        key_next   = key_reg;
        hdr_next   = hdr_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = pkind_reg;
                data_next  = pdata_reg;
            end
            else if (q_valid)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                pend_next  = q_head.two;
                kind_next  = q_head.kind0;
                data_next  = q_head.data0;
                pkind_next = q_head.kind1;
                pdata_next = q_head.data1;
                key_next   = q_head.key;
                hdr_next   = q_head.hdr;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        pkind_reg <= pkind_next;
        pdata_reg <= pdata_next;
        key_reg   <= key_next;
        hdr_reg   <= hdr_next;
    end

    // Drive the result ports; key and data only where the kind carries them
    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign version_word = hdr_reg.version;
    assign body_length  = hdr_reg.length;
    assign service_code = hdr_reg.service;
    assign status_code  = hdr_reg.status;
    assign session_word = hdr_reg.session;
    assign key_number   = (kind_reg == KIND_BYTE || kind_reg == KIND_VEND) ? key_reg : 16'd0;
    assign data_byte    = (kind_reg == KIND_BYTE) ? data_reg : 8'd0;

    a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg)
        else $error("second result pending without a shown result");

    a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_ready && pend_reg) |=> (valid_reg && !pend_reg))
        else $error("pending second result not shown next");

    a_no_pop_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !q_pop)
        else $error("queue popped while a second result waits");

endmodule

### design/keyed_packet_stream_parser_unit.sv
// Top level of the keyed packet stream parser.
// Instantiates kpsp_front, kpsp_queue and kpsp_back; depends on kpsp_pkg.
//
// Usage:
//   The stream channel (stream_valid/stream_ready/stream_byte) takes one raw
//   packet word per handshake. The result channel (result_valid/
//   result_ready and the field ports) gives header, value byte, value end
//   and packet end results in stream order, each carrying the most recent
//   header fields.
//   A word's results enter the queue at the edge that accepts it and then
//   load the output register once it is free.
//   Throughput: one word per cycle while each word causes at most one
//   result and result_ready stays high; a word causing two results shows
//   them one after the other from the output register. The two-entry
//   queue holds the results of up to two words.
//   Reset: the parser waits for a header, skipping zero padding; queue and
//   output register are empty.
//   Receiver stall: the shown result holds; the queue fills and then
//   stream_ready drops until the output moves again.
`timescale 1ns / 1ps

module keyed_packet_stream_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_valid,
    output logic        stream_ready,
    input  logic [7:0]  stream_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [31:0] version_word,
    output logic [15:0] body_length,
    output logic [15:0] service_code,
    output logic [31:0] status_code,
    output logic [31:0] session_word,
    output logic [15:0] key_number,
    output logic [7:0]  data_byte
);
    import kpsp_pkg::*;

    logic       q_full;
    logic       push;
    kpsp_step_t push_data;
    logic       q_valid;
    logic       q_pop;
    kpsp_step_t q_head;

    kpsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    kpsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    kpsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .version_word (version_word),
        .body_length  (body_length),
        .service_code (service_code),
        .status_code  (status_code),
        .session_word (session_word),
        .key_number   (key_number),
        .data_byte    (data_byte)
    );

endmodule

### tb/tb.sv
// Testbench for keyed_packet_stream_parser_unit: drives a byte stream of
// packets and checks every result against a cycle-free parser model.
// Depends on kpsp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb;
    import kpsp_pkg::*;

    localparam int RANDOM_WORDS   = 1380;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Parser phases of the model
    typedef enum logic [2:0] {
        WAIT_HDR,
        IN_HDR,
        IN_KEY,
        IN_VALUE,
        DROP_VALUE,
        SKIP_BODY,
        PEND_OWED
    } parse_phase_t;

    typedef struct {
        logic [1:0]  kind;
        kpsp_hdr_t   hdr;
        logic [15:0] key;
        logic [7:0]  data;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        stream_valid = 1'b0;
    logic        stream_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  kind;
    logic [31:0] version_word;
    logic [15:0] body_length;
    logic [15:0] service_code;
    logic [31:0] status_code;
    logic [31:0] session_word;
    logic [15:0] key_number;
    logic [7:0]  data_byte;

    keyed_packet_stream_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .version_word (version_word),
        .body_length  (body_length),
        .service_code (service_code),
        .status_code  (status_code),
        .session_word (session_word),
        .key_number   (key_number),
        .data_byte    (data_byte)
    );

    // Stimulus and scoreboard storage
    logic [7:0]    pending_bytes[$];
    logic [7:0]    body_buf[$];
    parse_result_t expected_results[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            calm_left = 0;
    bit            word_taken = 1'b0;

    // Parser model state
    parse_phase_t  phase_q = WAIT_HDR;
    logic [16:0]   count_q = '0;
    kpsp_hdr_t     hdr_q = '0;
    logic [15:0]   key_acc = '0;
    logic          key_nonempty = 1'b0;
    logic          key_bad = 1'b0;
    logic          held_valid = 1'b0;
    logic [7:0]    held_val = 8'h00;
    int            step_results = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------

    // Record one result; a word yields two at most
    function automatic void push_result(logic [1:0] k, logic [7:0] d);
        parse_result_t r;
        if (step_results > 1)
            return;
        r.kind = k;
        r.hdr  = hdr_q;
        r.key  = ((k == KIND_BYTE || k == KIND_VEND) && !key_bad) ? key_acc : 16'd0;
        r.data = (k == KIND_BYTE) ? d : 8'd0;
        expected_results.push_back(r);
        step_results++;
    endfunction

    function automatic void clear_key();
        key_acc      = '0;
        key_nonempty = 1'b0;
        key_bad      = 1'b0;
    endfunction

    // Fold one key character into the decimal accumulator
    function automatic void take_key_char(logic [7:0] b);
        int unsigned v;
        key_nonempty = 1'b1;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            if (!key_bad)
            begin
                v = 32'(key_acc) * 32'd10 + 32'(b - 8'h30);
                if (v > 32'hFFFF)
                    key_bad = 1'b1;
                else
                    key_acc = v[15:0];
            end
        end
        else
            key_bad = 1'b1;
    endfunction

    function automatic void take_header_byte(logic [7:0] b);
        if (count_q >= 4 && count_q <= 7)
            hdr_q.version = {hdr_q.version[23:0], b};
        else if (count_q >= 8 && count_q <= 9)
            hdr_q.length = {hdr_q.length[7:0], b};
        else if (count_q >= 10 && count_q <= 11)
            hdr_q.service = {hdr_q.service[7:0], b};
        else if (count_q >= 12 && count_q <= 15)
            hdr_q.status = {hdr_q.status[23:0], b};
        else if (count_q >= 16 && count_q <= 19)
            hdr_q.session = {hdr_q.session[23:0], b};
        count_q = count_q + 17'd1;
        if (count_q >= 17'(HDR_BYTES))
        begin
            push_result(KIND_HEADER, 8'h00);
            count_q = '0;
            clear_key();
            held_valid = 1'b0;
            if (hdr_q.length == 16'd0)
            begin
                push_result(KIND_PEND, 8'h00);
                phase_q = WAIT_HDR;
            end
            else
                phase_q = IN_KEY;
        end
    endfunction

    // Drop zero padding; any other word opens a header
    function automatic void take_idle_byte(logic [7:0] b);
        if (b == PAD_BYTE)
            return;
        phase_q = IN_HDR;
        count_q = '0;
        take_header_byte(b);
    endfunction

    // Body word known not to open a separator
    function automatic void use_body_byte(logic [7:0] b);
        if (phase_q == IN_KEY)
            take_key_char(b);
        else if (phase_q == IN_VALUE)
            push_result(KIND_BYTE, b);
    endfunction

    function automatic void close_part();
        if (phase_q == IN_KEY)
            phase_q = key_nonempty ? IN_VALUE : DROP_VALUE;
        else if (phase_q == IN_VALUE)
        begin
            push_result(KIND_VEND, 8'h00);
            clear_key();
            phase_q = IN_KEY;
        end
        else if (phase_q == DROP_VALUE)
        begin
            clear_key();
            phase_q = IN_KEY;
        end
    endfunction

    // Body word before the final one, not taken as a separator tail
    function automatic void offer_body_byte(logic [7:0] b);
        if (phase_q == SKIP_BODY)
            return;
        if (phase_q == IN_KEY && !key_nonempty && b == PAD_BYTE)
        begin
            phase_q = SKIP_BODY;
            return;
        end
        if (b == SEP_HI)
        begin
            held_valid = 1'b1;
            held_val   = b;
        end
        else
            use_body_byte(b);
    endfunction

    function automatic void take_body_byte(logic [7:0] b);
        logic last;
        last    = (({1'b0, count_q} + 18'd1) >= {2'd0, hdr_q.length});
        count_q = count_q + 17'd1;
        if (held_valid)
        begin
            held_valid = 1'b0;
            if (b == SEP_LO)
                close_part();
            else
            begin
                use_body_byte(held_val);
                if (!last)
                    offer_body_byte(b);
            end
        end
        else if (!last)
            offer_body_byte(b);
        if (last)
        begin
            if (phase_q == IN_VALUE || (phase_q == IN_KEY && key_nonempty))
                push_result(KIND_VEND, 8'h00);
            clear_key();
            held_valid = 1'b0;
            count_q    = '0;
            if (step_results < 2)
            begin
                push_result(KIND_PEND, 8'h00);
                phase_q = WAIT_HDR;
            end
            else
                phase_q = PEND_OWED;
        end
    endfunction

    function automatic void predict_word(logic [7:0] b);
        step_results = 0;
        case (phase_q)
            IN_HDR:
                take_header_byte(b);
            IN_KEY, IN_VALUE, DROP_VALUE, SKIP_BODY:
                take_body_byte(b);
            PEND_OWED:
            begin
                push_result(KIND_PEND, 8'h00);
                phase_q = WAIT_HDR;
                take_idle_byte(b);
            end
            default:
            begin
                phase_q = WAIT_HDR;
                take_idle_byte(b);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0 || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Body byte biased toward separator halves, zero and digits
    function automatic logic [7:0] rand_body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return SEP_HI;
        if (r < 16)
            return SEP_LO;
        if (r < 21)
            return PAD_BYTE;
        if (r < 35)
            return 8'(8'h30 + $urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_field32();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0;
        if (r < 20)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            body_buf.push_back(s[i]);
    endfunction

    function automatic void add_sep();
        body_buf.push_back(SEP_HI);
        body_buf.push_back(SEP_LO);
    endfunction

    // Queue padding, a header with the given length field, then the body;
    // the service field takes the low half of svc
    function automatic void queue_packet(int zeros, logic [31:0] ver, logic [31:0] svc,
                                         logic [31:0] st, logic [31:0] sess, int len);
        logic [15:0] len_field;
        logic [7:0]  magic;
        len_field = 16'(len);
        repeat (zeros) pending_bytes.push_back(PAD_BYTE);
        magic = 8'($urandom_range(1, 255));
        pending_bytes.push_back(magic);
        repeat (3)
        begin
            magic = 8'($urandom_range(0, 255));
            pending_bytes.push_back(magic);
        end
        for (int i = 3; i >= 0; i--)
            pending_bytes.push_back(ver[8*i +: 8]);
        pending_bytes.push_back(len_field[15:8]);
        pending_bytes.push_back(len_field[7:0]);
        pending_bytes.push_back(svc[15:8]);
        pending_bytes.push_back(svc[7:0]);
        for (int i = 3; i >= 0; i--)
            pending_bytes.push_back(st[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            pending_bytes.push_back(sess[8*i +: 8]);
        foreach (body_buf[i])
            pending_bytes.push_back(body_buf[i]);
        body_buf.delete();
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard reporting
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Stream driver: change inputs on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stream_valid && !word_taken)
            begin
                // hold the word until it is taken
            end
            else if (send_gap > 0)
            begin
                stream_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() != 0)
            begin
                stream_valid <= 1'b1;
                stream_byte  <= pending_bytes.pop_front();
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(50, 200);
                send_gap = pick_gap();
            end
            else
                stream_valid <= 1'b0;
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: sample handshakes on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n)
        begin
            word_taken = stream_valid && stream_ready;
            if (word_taken)
                predict_word(stream_byte);

            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d of kind %0d with nothing pending",
                                              results_seen, kind));
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("kind", 32'(kind), 32'(want.kind));
                    compare_field("version_word", version_word, want.hdr.version);
                    compare_field("body_length", 32'(body_length), 32'(want.hdr.length));
                    compare_field("service_code", 32'(service_code),
                                  32'(want.hdr.service));
                    compare_field("status_code", status_code, want.hdr.status);
                    compare_field("session_word", session_word, want.hdr.session);
                    compare_field("key_number", 32'(key_number), 32'(want.key));
                    compare_field("data_byte", 32'(data_byte), 32'(want.data));
                end
                results_seen++;
            end

            // Watchdog on cycles with no handshake on either side
            if (word_taken || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int r;
        int t;
        int n_pairs;
        int max_val;
        int len;
        int directed_total;

        // Empty body after zero padding, header fields all zero
        queue_packet(2, 32'h0, 32'h0, 32'h0, 32'h0, 0);

        // Largest key, non-digit key, overflowing key, empty key, C0 inside
        // a value, final byte never copied; header fields but the length all ones
        add_text("65535"); add_sep(); add_text("ab"); add_sep();
        add_text("7z"); add_sep(); add_text("q"); add_sep();
        add_text("65536"); add_sep(); add_text("v"); add_sep();
        add_sep(); add_text("gone"); add_sep();
        add_text("12"); add_sep();
        body_buf.push_back(SEP_HI); add_text("A"); body_buf.push_back(SEP_HI);
        add_sep(); add_text("9");
        queue_packet(0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     body_buf.size());

        // Final byte completes a separator
        add_text("4"); add_sep(); add_text("z"); add_sep();
        queue_packet(1, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());

        // Held C0 before the final byte turns into a value byte: packet end
        // is owed to the next word, once a header start, once padding
        add_text("5"); add_sep(); add_text("v"); body_buf.push_back(SEP_HI); add_text("w");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());
        add_text("6"); add_sep(); body_buf.push_back(SEP_HI); add_text("x");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());
        queue_packet(2, $urandom(), $urandom(), $urandom(), $urandom(), 0);

        // Zero at pair start skips the rest; also zero as the first body byte
        add_text("1"); add_sep(); add_text("a"); add_sep();
        body_buf.push_back(PAD_BYTE); add_text("2"); add_sep(); add_text("b"); add_sep();
        add_text("c");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());
        body_buf.push_back(PAD_BYTE); add_text("3"); add_sep(); add_text("d");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());

        // Body ends inside a pair: empty value, and key with no separator
        add_text("8"); add_sep(); add_text("x");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());
        add_text("77"); add_text("1");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());

        // One-byte body; C0 in a key not followed by 80
        add_text("k");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), 1);
        add_text("1"); body_buf.push_back(SEP_HI); add_text("2"); add_sep();
        add_text("e"); add_sep(); add_text("0");
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), body_buf.size());

        directed_total = pending_bytes.size();

        // Random packets: mostly well formed with random content
        while (pending_bytes.size() < directed_total + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    n_pairs = $urandom_range(5, 12);
                    max_val = 40;
                end
                else
                begin
                    n_pairs = $urandom_range(0, 4);
                    max_val = 6;
                end
                repeat (n_pairs)
                begin
                    t = $urandom_range(0, 99);
                    if (t < 15)
                    begin
                        // empty key
                    end
                    else if (t < 25)
                        add_text($sformatf("%0dx%0d", $urandom_range(0, 99),
                                           $urandom_range(0, 9)));
                    else if (t < 30)
                        repeat ($urandom_range(1, 3)) body_buf.push_back(rand_body_byte());
                    else if (t < 38)
                        case ($urandom_range(0, 4))
                            0: add_text("65535");
                            1: add_text("65536");
                            2: add_text("99999");
                            3: add_text("0065535");
                            default: add_text("123456");
                        endcase
                    else if (t < 80)
                        add_text($sformatf("%0d", $urandom_range(0, 999)));
                    else
                        add_text($sformatf("%0d", $urandom_range(0, 65535)));
                    add_sep();
                    repeat ($urandom_range(0, max_val)) body_buf.push_back(rand_body_byte());
                    add_sep();
                end
                case ($urandom_range(0, 5))
                    0: body_buf.push_back(rand_body_byte());
                    1:
                    begin
                        add_text($sformatf("%0d", $urandom_range(0, 9999)));
                        body_buf.push_back(rand_body_byte());
                    end
                    2:
                    begin
                        body_buf.push_back(PAD_BYTE);
                        repeat ($urandom_range(0, 6)) body_buf.push_back(rand_body_byte());
                    end
                    3:
                    begin
                        add_text($sformatf("%0d", $urandom_range(0, 99)));
                        add_sep();
                        repeat ($urandom_range(0, 2)) body_buf.push_back(rand_body_byte());
                        body_buf.push_back(SEP_HI);
                        body_buf.push_back(8'($urandom_range(0, 127)));
                    end
                    4:
                    begin
                        add_text($sformatf("%0d", $urandom_range(0, 99)));
                        add_sep();
                        repeat ($urandom_range(0, 3)) body_buf.push_back(rand_body_byte());
                        add_sep();
                    end
                    default:
                    begin
                        // body is just the pairs
                    end
                endcase
                len = body_buf.size();
            end
            else if (r < 95)
            begin
                // noise body
                repeat ($urandom_range(1, 30)) body_buf.push_back(rand_body_byte());
                len = body_buf.size();
            end
            else
            begin
                // length field may disagree with the body sent
                repeat ($urandom_range(0, 12)) body_buf.push_back(rand_body_byte());
                len = body_buf.size() + $urandom_range(0, 4) - 2;
                if (len < 0)
                    len = 0;
            end
            queue_packet(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3),
                         pick_field32(), pick_field32(), pick_field32(), pick_field32(), len);
        end

        // Largest length field; the stream ends inside this body
        repeat (10) body_buf.push_back(rand_body_byte());
        queue_packet(0, $urandom(), $urandom(), $urandom(), $urandom(), 65535);

        // Reset, released on a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Drain stimulus, then results, then watch for stray results
        while (pending_bytes.size() != 0 || stream_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
